FILE: rtl/pmbg_pkg.sv
package pmbg_pkg;

  localparam int unsigned EntryW  = 3;
  localparam int unsigned RegW    = 24;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [RegW-1:0] MixPermReset   = 24'hFAC688;
  localparam logic [RegW-1:0] StartPermReset = 24'h1F58D1;

  localparam logic CmdRestart  = 1'b0;
  localparam logic CmdGenerate = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    RegMixPerm   = 2'd0,
    RegMixInv    = 2'd1,
    RegStartPerm = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [RegW-1:0] mix_perm;
    logic [RegW-1:0] mix_inv;
    logic [RegW-1:0] start_perm;
  } cfg_t;

endpackage

FILE: rtl/pmbg_cfg.sv
module pmbg_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pmbg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pmbg_pkg::RegW-1:0]      cfg_data_i,
  output pmbg_pkg::cfg_t                 cfg_o
);

  pmbg_pkg::cfg_t cfg_q;
  pmbg_pkg::cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (pmbg_pkg::reg_idx_e'(cfg_index_i))
        pmbg_pkg::RegMixPerm:   cfg_d.mix_perm   = cfg_data_i;
        pmbg_pkg::RegMixInv:    cfg_d.mix_inv    = cfg_data_i;
        pmbg_pkg::RegStartPerm: cfg_d.start_perm = cfg_data_i;
        default:                cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mix_perm   <= pmbg_pkg::MixPermReset;
      cfg_q.mix_inv    <= pmbg_pkg::MixPermReset;
      cfg_q.start_perm <= pmbg_pkg::StartPermReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/pmbg_core.sv
module pmbg_core #(
  parameter int unsigned STATE_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          cmd_i,
  input  logic [pmbg_pkg::RegW-1:0]     swap_indices_i,
  input  pmbg_pkg::cfg_t                cfg_i,
  output logic [pmbg_pkg::ByteW-1:0]    random_byte_o
);

  localparam int unsigned IdxW    = $clog2(STATE_BITS);
  localparam int unsigned PermW   = pmbg_pkg::EntryW * STATE_BITS;
  localparam int unsigned WideW   = (PermW > pmbg_pkg::RegW) ? PermW : pmbg_pkg::RegW;
  localparam int unsigned OutPadW = (STATE_BITS > pmbg_pkg::ByteW) ? STATE_BITS
                                                                    : pmbg_pkg::ByteW;
  localparam logic [STATE_BITS-1:0] StartState = STATE_BITS'((1 << (STATE_BITS / 2)) - 1);
  localparam logic [WideW-1:0]      StartWide  = WideW'(pmbg_pkg::StartPermReset);
  localparam logic [PermW-1:0]      PermReset  = StartWide[PermW-1:0];

  function automatic logic [IdxW-1:0] reduce(input logic [pmbg_pkg::EntryW-1:0] v);
    logic [4:0] t;
    t = {2'b00, v};
    if (t >= 5'(STATE_BITS)) t = t - 5'(STATE_BITS);
    return t[IdxW-1:0];
  endfunction

  logic [STATE_BITS-1:0] state_q;
  logic [STATE_BITS-1:0] state_d;
  logic [PermW-1:0]      perm_q;
  logic [PermW-1:0]      perm_d;

  logic [WideW-1:0]      mix_w;
  logic [WideW-1:0]      inv_w;
  logic [WideW-1:0]      swp_w;
  logic [WideW-1:0]      start_w;
  logic [IdxW-1:0]       mix_e [STATE_BITS];
  logic [IdxW-1:0]       inv_e [STATE_BITS];
  logic [IdxW-1:0]       cyc_e [STATE_BITS];
  logic [IdxW-1:0]       swp_e [STATE_BITS];
  logic [STATE_BITS-1:0] upd;
  logic [STATE_BITS-1:0] swp;
  logic [PermW-1:0]      new_perm;
  logic [OutPadW-1:0]    out_w;
  logic                  tmp;

  assign mix_w   = WideW'(cfg_i.mix_perm);
  assign inv_w   = WideW'(cfg_i.mix_inv);
  assign swp_w   = WideW'(swap_indices_i);
  assign start_w = WideW'(cfg_i.start_perm);

  always_comb begin
    for (int i = 0; i < STATE_BITS; i++) begin
      mix_e[i] = reduce(mix_w[pmbg_pkg::EntryW*i +: pmbg_pkg::EntryW]);
      inv_e[i] = reduce(inv_w[pmbg_pkg::EntryW*i +: pmbg_pkg::EntryW]);
      cyc_e[i] = reduce(perm_q[pmbg_pkg::EntryW*i +: pmbg_pkg::EntryW]);
      swp_e[i] = reduce(swp_w[pmbg_pkg::EntryW*i +: pmbg_pkg::EntryW]);
    end

    // in-place update, lower bits already new
    upd = state_q;
    for (int i = 0; i < STATE_BITS; i++) begin
      upd[i] = upd[i] ^ upd[cyc_e[i]];
    end

    // conjugate with the mixing permutation
    for (int i = 0; i < STATE_BITS; i++) begin
      new_perm[pmbg_pkg::EntryW*i +: pmbg_pkg::EntryW] =
        pmbg_pkg::EntryW'(mix_e[cyc_e[inv_e[i]]]);
    end

    // swaps on the output copy only
    swp = upd;
    tmp = 1'b0;
    for (int i = 0; i < STATE_BITS; i++) begin
      tmp           = swp[i];
      swp[i]        = swp[swp_e[i]];
      swp[swp_e[i]] = tmp;
    end

    out_w = OutPadW'(swp);

    if (cmd_i == pmbg_pkg::CmdGenerate) begin
      state_d       = upd;
      perm_d        = new_perm;
      random_byte_o = out_w[pmbg_pkg::ByteW-1:0];
    end else begin
      state_d       = StartState;
      perm_d        = start_w[PermW-1:0];
      random_byte_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StartState;
      perm_q  <= PermReset;
    end else if (adv_i) begin
      state_q <= state_d;
      perm_q  <= perm_d;
    end
  end

endmodule

FILE: rtl/permutation_mix_bit_generator.sv
// throughput: one item per cycle unless out_stall_i holds a result, set
// by the combinational state update and permutation conjugation between
// the stage-1 input registers and the result register behind out_valid_o
// reset: asynchronous, active low; clears the pipeline valids, loads the
// state with its lower half set, the cycle permutation and all three
// configuration registers with their defaults
module permutation_mix_bit_generator #(
  parameter int unsigned STATE_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [pmbg_pkg::RegW-1:0]     swap_indices_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pmbg_pkg::ByteW-1:0]    random_byte_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pmbg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pmbg_pkg::RegW-1:0]     cfg_data_i
);

  pmbg_pkg::cfg_t cfg;

  logic                       s1_vld_q;
  logic                       s1_vld_d;
  logic                       s1_cmd_q;
  logic [pmbg_pkg::RegW-1:0]  s1_swap_q;
  logic                       out_vld_q;
  logic                       out_vld_d;
  logic [pmbg_pkg::ByteW-1:0] out_byte_q;
  logic [pmbg_pkg::ByteW-1:0] out_byte_d;
  logic                       out_free;
  logic                       s1_adv;
  logic                       in_acc;

  pmbg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pmbg_core #(
    .STATE_BITS (STATE_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (s1_adv),
    .cmd_i          (s1_cmd_q),
    .swap_indices_i (s1_swap_q),
    .cfg_i          (cfg),
    .random_byte_o  (out_byte_d)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign s1_adv     = s1_vld_q && out_free;
  assign in_stall_o = s1_vld_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign s1_vld_d  = in_acc || (s1_vld_q && !s1_adv);
  assign out_vld_d = s1_adv || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q  <= cmd_i;
      s1_swap_q <= swap_indices_i;
    end
    if (s1_adv) begin
      out_byte_q <= out_byte_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign random_byte_o = out_byte_q;

endmodule

FILE: rtl/pmbg_checker.sv
module pmbg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          cmd_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [pmbg_pkg::ByteW-1:0]    random_byte_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(random_byte_o))
    else $error("stalled result changed or dropped");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without an accepted item");

  a_restart_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) &&
      $past(in_valid_i && !in_stall_o && (cmd_i == pmbg_pkg::CmdRestart), 2)
      |-> random_byte_o == '0)
    else $error("restart item gave a non-zero byte");

endmodule

bind permutation_mix_bit_generator pmbg_checker u_pmbg_checker (.*);
